// ----- rtl/lea_pkg.sv -----
package lea_pkg;

  // default of the line store depth
  localparam int unsigned LINE_MAX_DEF = 32;

  localparam logic [7:0] BYTE_CLR = 8'd0;
  localparam logic [7:0] BYTE_BS  = 8'd8;
  localparam logic [7:0] BYTE_LF  = 8'd10;
  localparam logic [7:0] BYTE_CR  = 8'd13;

  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_CHAR = 2'd1;
  localparam logic [1:0] KIND_TERM = 2'd2;

  // one result word handed from the sequencer to the output register
  typedef struct packed {
    logic       load;
    logic [1:0] kind;
    logic [7:0] data;
    logic       overflow;
    logic       last;
  } lea_res_t;

endpackage

// ----- rtl/lea_ram.sv -----
module lea_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/lea_seq.sv -----
module lea_seq
  import lea_pkg::*;
#(
  parameter int unsigned LINE_MAX = LINE_MAX_DEF,
  localparam int unsigned AddrW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1,
  localparam int unsigned LenW  = $clog2(LINE_MAX + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             echo_i,
  input  logic             in_valid_i,
  input  logic [7:0]       rx_byte_i,
  output logic             in_stall_o,
  input  logic             out_free_i,
  output lea_res_t         res_o,
  output logic             wr_en_o,
  output logic [AddrW-1:0] wr_addr_o,
  output logic [7:0]       wr_data_o,
  output logic             rd_en_o,
  output logic [AddrW-1:0] rd_addr_o,
  input  logic [7:0]       rd_data_i
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ECHO = 5'b00010,
    S_READ = 5'b00100,
    S_CHAR = 5'b01000,
    S_TERM = 5'b10000
  } state_e;

  localparam logic [LenW-1:0] LenMax = LenW'(LINE_MAX);

  state_e           state_q, state_d;
  logic [LenW-1:0]  len_q, len_d;
  logic             ale_q, ale_d;
  logic             drop_q, drop_d;
  logic             emit_q, emit_d;
  logic [7:0]       byte_q, byte_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic             line_empty;
  logic             is_le;
  state_e           line_start;

  assign line_empty = (len_q == '0);
  assign line_start = line_empty ? S_TERM : S_READ;
  assign is_le      = (rx_byte_i == BYTE_LF) || (rx_byte_i == BYTE_CR);

  assign in_stall_o = (state_q != S_IDLE);
  assign wr_addr_o  = len_q[AddrW-1:0];
  assign wr_data_o  = rx_byte_i;
  assign rd_addr_o  = idx_q;

  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    ale_d   = ale_q;
    drop_d  = drop_q;
    emit_d  = emit_q;
    byte_d  = byte_q;
    idx_d   = idx_q;
    wr_en_o = 1'b0;
    rd_en_o = 1'b0;
    res_o   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          byte_d = rx_byte_i;
          idx_d  = '0;
          emit_d = 1'b0;
          case (rx_byte_i) inside
            BYTE_CLR: begin
              len_d  = '0;
              drop_d = 1'b0;
              ale_d  = 1'b0;
            end
            BYTE_BS: begin
              if (!line_empty) begin
                len_d = len_q - 1'b1;
              end
              ale_d = 1'b0;
            end
            BYTE_LF, BYTE_CR: begin
              // empty line right after a line end is swallowed (crlf)
              if (line_empty && ale_q) begin
                ale_d = 1'b0;
              end else begin
                emit_d = 1'b1;
              end
            end
            default: begin
              if (len_q < LenMax) begin
                wr_en_o = 1'b1;
                len_d   = len_q + 1'b1;
              end else begin
                drop_d = 1'b1;
              end
              ale_d = 1'b0;
            end
          endcase
          if (echo_i) begin
            state_d = S_ECHO;
          end else if (is_le && !(line_empty && ale_q)) begin
            state_d = line_start;
          end
        end
      end
      S_ECHO: begin
        if (out_free_i) begin
          res_o.load = 1'b1;
          res_o.kind = KIND_ECHO;
          res_o.data = byte_q;
          res_o.last = !emit_q;
          state_d    = emit_q ? line_start : S_IDLE;
        end
      end
      S_READ: begin
        rd_en_o = 1'b1;
        state_d = S_CHAR;
      end
      S_CHAR: begin
        if (out_free_i) begin
          res_o.load = 1'b1;
          res_o.kind = KIND_CHAR;
          res_o.data = rd_data_i;
          idx_d      = idx_q + 1'b1;
          state_d    = ((LenW'(idx_q) + 1'b1) == len_q) ? S_TERM : S_READ;
        end
      end
      S_TERM: begin
        if (out_free_i) begin
          res_o.load     = 1'b1;
          res_o.kind     = KIND_TERM;
          res_o.overflow = drop_q;
          res_o.last     = 1'b1;
          len_d          = '0;
          drop_d         = 1'b0;
          ale_d          = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
      ale_q   <= 1'b0;
      drop_q  <= 1'b0;
      emit_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      ale_q   <= ale_d;
      drop_q  <= drop_d;
      emit_q  <= emit_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

endmodule

// ----- rtl/line_editor_assembler_core.sv -----
// line editor / assembler: builds text lines from received bytes
// input channel: one byte per word on rx_byte_i, in_valid_i / in_stall_o
// output channel: kind_o, data_o, overflow_o, last_o words, out_valid_o / out_stall_i
// config channel: cfg_echo_enable_i written when cfg_valid_i and cfg_ready_o
//   (always ready); write it only while the block is idle
// every result passes through one output register, so a stalled receiver
// only holds the sequencer, and the held word stays put
// timing: a byte that gives no result is taken every cycle; with echo on a
// byte waits in the echo state until its echo word is loaded; a line end then
// passes a read and a character state per stored character, then the
// terminator state, set by the one read port of the line store, which needs a
// read before each character word; the first result is loaded from the state
// entered as the byte is taken (after the read state for a stored character)
// reset: line empty, echo off, output empty; store contents are don't-care
module line_editor_assembler_core
  import lea_pkg::*;
#(
  parameter int unsigned LINE_MAX = LINE_MAX_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] data_o,
  output logic       overflow_o,
  output logic       last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_echo_enable_i
);

  localparam int unsigned AddrW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

  lea_res_t         res;
  logic             echo_q;
  logic             out_valid_q;
  logic [1:0]       kind_q;
  logic [7:0]       data_q;
  logic             overflow_q;
  logic             last_q;
  logic             out_free;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [7:0]       rd_data;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  lea_seq #(
    .LINE_MAX(LINE_MAX)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .echo_i    (echo_q),
    .in_valid_i(in_valid_i),
    .rx_byte_i (rx_byte_i),
    .in_stall_o(in_stall_o),
    .out_free_i(out_free),
    .res_o     (res),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data)
  );

  lea_ram #(
    .WIDTH(8),
    .DEPTH(LINE_MAX)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        echo_q <= cfg_echo_enable_i;
      end
      if (res.load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.load) begin
      kind_q     <= res.kind;
      data_q     <= res.data;
      overflow_q <= res.overflow;
      last_q     <= res.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign data_o      = data_q;
  assign overflow_o  = overflow_q;
  assign last_o      = last_q;

  // a word is only loaded into a free output register
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.load |-> out_free)
    else $error("result loaded over a held word");

  // a byte is never taken while the sequencer is producing a word
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !res.load)
    else $error("byte taken during result emission");

  // terminators close the byte's results; overflow only rides on terminators
  a_term_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_TERM) |-> last_o)
    else $error("terminator not marked last");

  a_ovf_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |-> (kind_o == KIND_TERM))
    else $error("overflow on a non-terminator word");

endmodule

// ----- tb/sv/tb.sv -----
module tb;
  import lea_pkg::*;

  localparam int QUIET_CYCLES = 80;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       overflow;
    logic       last;
  } word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] rx_byte_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [1:0] kind_o;
  logic [7:0] data_o;
  logic       overflow_o;
  logic       last_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_echo_enable_i = 1'b0;

  // line tracking state of the prediction
  logic       echo_on = 1'b0;
  logic [7:0] line_buf [LINE_MAX_DEF];
  int         line_len = 0;
  logic       after_eol = 1'b0;
  logic       dropped = 1'b0;

  word_t      expected_words [$];
  word_t      got_w;
  word_t      want_w;
  int         mismatches = 0;
  int         bytes_taken = 0;
  bit         idle_on = 1'b1;

  line_editor_assembler_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .data_o           (data_o),
    .overflow_o       (overflow_o),
    .last_o           (last_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_echo_enable_i(cfg_echo_enable_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb: done, errors");
    $finish;
  end

  function automatic void push_word(input logic [1:0] kind, input logic [7:0] data,
                                    input logic ovf);
    word_t w;
    w.kind = kind;
    w.data = data;
    w.overflow = ovf;
    w.last = 1'b0;
    expected_words.push_back(w);
  endfunction

  function automatic void predict_byte(input logic [7:0] b);
    int    first;
    word_t w;
    first = expected_words.size();
    if (echo_on) begin
      push_word(KIND_ECHO, b, 1'b0);
    end
    if (b == BYTE_CLR) begin
      line_len = 0;
      dropped = 1'b0;
      after_eol = 1'b0;
    end else if (b == BYTE_BS) begin
      if (line_len > 0) begin
        line_len--;
      end
      after_eol = 1'b0;
    end else if (b == BYTE_LF || b == BYTE_CR) begin
      // second byte of a line end pair reports no line (only its echo, if on)
      if (line_len == 0 && after_eol) begin
        after_eol = 1'b0;
      end else begin
        for (int k = 0; k < line_len; k++) begin
          push_word(KIND_CHAR, line_buf[k], 1'b0);
        end
        push_word(KIND_TERM, 8'd0, dropped);
        line_len = 0;
        dropped = 1'b0;
        after_eol = 1'b1;
      end
    end else begin
      if (line_len < LINE_MAX_DEF) begin
        line_buf[line_len] = b;
        line_len++;
      end else begin
        dropped = 1'b1;
      end
      after_eol = 1'b0;
    end
    if (expected_words.size() > first) begin
      w = expected_words.pop_back();
      w.last = 1'b1;
      expected_words.push_back(w);
    end
  endfunction

  always @(posedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(99) < 35);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_w.kind = kind_o;
      got_w.data = data_o;
      got_w.overflow = overflow_o;
      got_w.last = last_o;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("tb: unexpected word kind=%0d data=%02h ovf=%0b last=%0b",
                   got_w.kind, got_w.data, got_w.overflow, got_w.last);
        end
      end else begin
        want_w = expected_words.pop_front();
        if (got_w !== want_w) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("tb: mismatch exp kind=%0d data=%02h ovf=%0b last=%0b,",
                   want_w.kind, want_w.data, want_w.overflow, want_w.last);
            $display(" got kind=%0d data=%02h ovf=%0b last=%0b",
                     got_w.kind, got_w.data, got_w.overflow, got_w.last);
          end
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (idle_on && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    predict_byte(b);
    bytes_taken++;
  endtask

  // hold off the sender until every expected word has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_words.size() != 0);
  endtask

  task automatic set_echo(input logic v);
    wait_drained();
    // bytes without any result may still be in flight
    repeat (QUIET_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_echo_enable_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    echo_on = v;
  endtask

  function automatic logic [7:0] ordinary_byte();
    logic [7:0] b;
    b = 8'($urandom_range(1, 255));
    if (b == BYTE_BS || b == BYTE_LF || b == BYTE_CR) begin
      b = b | 8'h40;
    end
    return b;
  endfunction

  task automatic test_plain_lines();
    send_byte(8'h61);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(BYTE_BS);
    send_byte(BYTE_CR);
    send_byte(BYTE_LF);
    send_byte(BYTE_LF);
    send_byte(BYTE_BS);
    send_byte(BYTE_CR);
    send_byte(8'h78);
    send_byte(BYTE_CLR);
    send_byte(BYTE_CR);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(BYTE_LF);
  endtask

  task automatic test_full_line();
    // two characters past a full store, then edit and close
    for (int k = 0; k < LINE_MAX_DEF + 2; k++) begin
      send_byte(8'(8'h20 + k));
    end
    send_byte(BYTE_BS);
    send_byte(8'h7E);
    send_byte(BYTE_CR);
    send_byte(BYTE_CR);
    // clear drops the overflow mark
    for (int k = 0; k < LINE_MAX_DEF + 1; k++) begin
      send_byte(8'h7A);
    end
    send_byte(BYTE_CLR);
    send_byte(8'h71);
    send_byte(BYTE_LF);
  endtask

  task automatic test_echo_lines();
    send_byte(BYTE_CR);
    send_byte(BYTE_LF);
    send_byte(BYTE_BS);
    send_byte(BYTE_CLR);
    send_byte(8'hFF);
    send_byte(8'h41);
    send_byte(BYTE_BS);
    send_byte(8'h42);
    send_byte(BYTE_LF);
    send_byte(BYTE_LF);
  endtask

  task automatic run_random_lines(input int count);
    int stop_at;
    int len;
    stop_at = bytes_taken + count;
    while (bytes_taken < stop_at) begin
      if ($urandom_range(5) == 0) begin
        // noise: any byte values at all
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 8);
        repeat (len) begin
          send_byte(ordinary_byte());
          if ($urandom_range(7) == 0) begin
            send_byte(BYTE_BS);
          end
        end
        case ($urandom_range(3))
          0: send_byte(BYTE_CR);
          1: send_byte(BYTE_LF);
          2: begin
            send_byte(BYTE_CR);
            send_byte(BYTE_LF);
          end
          default: begin
            send_byte(BYTE_LF);
            send_byte(BYTE_CR);
          end
        endcase
      end
      if ($urandom_range(9) == 0) begin
        wait_drained();
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_plain_lines();
    test_full_line();
    set_echo(1'b1);
    test_echo_lines();
    run_random_lines(8);
    set_echo(1'b0);
    run_random_lines(8);
    set_echo(1'b1);
    idle_on = 1'b0;
    run_random_lines(10);
    idle_on = 1'b1;
    wait_drained();
    repeat (QUIET_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/lea_pkg.sv
rtl/lea_ram.sv
rtl/lea_seq.sv
rtl/line_editor_assembler_core.sv
tb/sv/tb.sv
